/* src/bac_pkg.sv */
// Package for the BCD alarm clock: widths, item kinds, sequencer states, step modes.
`timescale 1ns / 1ps
`default_nettype none
package bac_pkg;

  localparam int TIME_W = 22;
  localparam int KIND_W = 3;
  localparam int MIN_W  = 8;
  localparam int TPS_W  = 16;

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

  typedef logic [TIME_W-1:0] bcd_time_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_SET_TIME  = 3'd1,
    KIND_SET_ALARM = 3'd2,
    KIND_ENABLE    = 3'd3,
    KIND_DISABLE   = 3'd4,
    KIND_SNOOZE    = 3'd5,
    KIND_QUERY     = 3'd6
  } kind_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SNOOZE = 1'b1
  } seq_state_t;

  typedef enum logic {
    STEP_SEC = 1'b0,
    STEP_MIN = 1'b1
  } step_mode_t;

endpackage
`default_nettype wire

/* src/bac_if.sv */
// Valid/ready channel interfaces for the alarm clock input items and results.
`timescale 1ns / 1ps
`default_nettype none
interface bac_in_if;
  logic                          valid;
  logic                          ready;
  logic [bac_pkg::KIND_W-1:0]    kind;
  logic [bac_pkg::TIME_W-1:0]    time_value;
  logic [bac_pkg::MIN_W-1:0]     snooze_minutes;

  modport source (output valid, output kind, output time_value, output snooze_minutes,
                  input ready);
  modport sink   (input valid, input kind, input time_value, input snooze_minutes,
                  output ready);
endinterface

interface bac_out_if;
  logic                          valid;
  logic                          ready;
  logic [bac_pkg::TIME_W-1:0]    clock_time;
  logic [bac_pkg::TIME_W-1:0]    alarm_value;
  logic                          time_valid;
  logic                          alarm_on;
  logic                          alarm_fired;

  modport source (output valid, output clock_time, output alarm_value,
                  output time_valid, output alarm_on, output alarm_fired, input ready);
  modport sink   (input valid, input clock_time, input alarm_value,
                  input time_valid, input alarm_on, input alarm_fired, output ready);
endinterface
`default_nettype wire

/* src/bac_step.sv */
// Shared BCD step unit: adds one second or one minute with the 24-hour wrap.
`timescale 1ns / 1ps
`default_nettype none
module bac_step (
  input  wire bac_pkg::bcd_time_t   val_in,
  input  wire bac_pkg::step_mode_t  mode,
  output bac_pkg::bcd_time_t        val_out
);
  import bac_pkg::*;

  logic [4:0] s0_inc, s1_inc, m0_inc, m1_inc, h0_inc;
  logic [2:0] h1_inc;
  logic [3:0] s0, s1, m0, m1, h0;
  logic [2:0] h1;
  logic       c_min, c_hr;

  always_comb begin
    s0_inc = {1'b0, val_in[3:0]}   + 5'd1;
    s1_inc = {1'b0, val_in[7:4]}   + 5'd1;
    m0_inc = {1'b0, val_in[11:8]}  + 5'd1;
    m1_inc = {1'b0, val_in[15:12]} + 5'd1;
    h0_inc = {1'b0, val_in[19:16]} + 5'd1;
    h1_inc = {1'b0, val_in[21:20]} + 3'd1;

    s0 = val_in[3:0];
    s1 = val_in[7:4];
    m0 = val_in[11:8];
    m1 = val_in[15:12];
    h0 = val_in[19:16];
    h1 = {1'b0, val_in[21:20]};
    c_min = 1'b0;
    c_hr  = 1'b0;

    // seconds, only in second mode
    if (mode == STEP_SEC) begin
      if (s0_inc > 5'd9) begin
        s0 = 4'd0;
        if (s1_inc > 5'd5) begin
          s1    = 4'd0;
          c_min = 1'b1;
        end else begin
          s1 = s1_inc[3:0];
        end
      end else begin
        s0 = s0_inc[3:0];
      end
    end else begin
      c_min = 1'b1;
    end

    if (c_min) begin
      if (m0_inc > 5'd9) begin
        m0 = 4'd0;
        if (m1_inc > 5'd5) begin
          m1   = 4'd0;
          c_hr = 1'b1;
        end else begin
          m1 = m1_inc[3:0];
        end
      end else begin
        m0 = m0_inc[3:0];
      end
    end

    if (c_hr) begin
      if (h0_inc > 5'd9) begin
        h0 = 4'd0;
        h1 = h1_inc;
      end else begin
        h0 = h0_inc[3:0];
      end
    end

    // 24:00 and any out-of-range hour after a carry wraps the whole time
    if (c_hr && ((h1 > 3'd2) || ((h1 == 3'd2) && (h0 > 4'd3)))) begin
      val_out = '0;
    end else begin
      val_out = {h1[1:0], h0, m1, m0, s1, s0};
    end
  end

endmodule
`default_nettype wire

/* src/bcd_alarm_clock_core.sv */
// Top level of the BCD real-time clock with alarm: state, sequencer and channels.
//
//  channel   dir  beat contents
//  --------  ---  ----------------------------------------------------------
//  in_ch     in   kind, time_value (packed BCD hhmmss), snooze_minutes
//  out_ch    out  clock_time, alarm_value, time_valid, alarm_on, alarm_fired
//  cfg_*     in   cfg_we / cfg_wdata: ticks per second, written in any cycle with cfg_we high
//
// Every kind but snooze finishes in the accept cycle; its result beat is up the
// next cycle. Snooze by N > 0 minutes runs the shared step unit one minute per
// cycle, so its result beat comes up only after all N minutes are added.
// The result beat is read straight from the state registers, so in_ch.ready is
// low while a beat waits (it rises in the cycle out_ch.ready takes it) and during
// a snooze run. Reset (rst_n low, synchronous) clears the clock state and loads
// 1000 ticks.
`timescale 1ns / 1ps
`default_nettype none
module bcd_alarm_clock_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [bac_pkg::TPS_W-1:0]    cfg_wdata,
  bac_in_if.sink                      in_ch,
  bac_out_if.source                   out_ch
);
  import bac_pkg::*;

  seq_state_t        state_r, state_nxt;
  bcd_time_t         time_r, time_nxt;
  bcd_time_t         alarm_r, alarm_nxt;
  logic              tvalid_r, tvalid_nxt;
  logic              en_r, en_nxt;
  logic              fired_r, fired_nxt;
  logic [TPS_W-1:0]  pre_r, pre_nxt;
  logic [TPS_W-1:0]  tps_r;
  logic [MIN_W-1:0]  cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic              accept;
  logic [TPS_W-1:0]  pre_inc;
  bcd_time_t         unit_in, unit_out;
  step_mode_t        unit_mode;

  // one step unit serves both the seconds advance and the snooze loop
  bac_step u_step (
    .val_in  (unit_in),
    .mode    (unit_mode),
    .val_out (unit_out)
  );

  assign in_ch.ready = (state_r == ST_IDLE) && (!ovalid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = ovalid_r;
  assign out_ch.clock_time   = time_r;
  assign out_ch.alarm_value  = alarm_r;
  assign out_ch.time_valid   = tvalid_r;
  assign out_ch.alarm_on     = en_r;
  assign out_ch.alarm_fired  = fired_r;

  assign unit_in   = (state_r == ST_SNOOZE) ? alarm_r : time_r;
  assign unit_mode = (state_r == ST_SNOOZE) ? STEP_MIN : STEP_SEC;
  assign pre_inc   = pre_r + TPS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      time_r   <= '0;
      alarm_r  <= '0;
      tvalid_r <= 1'b0;
      en_r     <= 1'b0;
      fired_r  <= 1'b0;
      pre_r    <= '0;
      tps_r    <= TPS_RESET;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      alarm_r  <= alarm_nxt;
      tvalid_r <= tvalid_nxt;
      en_r     <= en_nxt;
      fired_r  <= fired_nxt;
      pre_r    <= pre_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    time_nxt   = time_r;
    alarm_nxt  = alarm_r;
    tvalid_nxt = tvalid_r;
    en_nxt     = en_r;
    fired_nxt  = fired_r;
    pre_nxt    = pre_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovalid_nxt = 1'b1;
          case (kind_t'(in_ch.kind))
            KIND_TICK: begin
              // prescaler runs only once a time is set
              if (tvalid_r) begin
                pre_nxt = pre_inc;
                if (pre_inc >= tps_r) begin
                  pre_nxt  = '0;
                  time_nxt = unit_out;
                  if (en_r && (unit_out == alarm_r)) begin
                    fired_nxt = 1'b1;
                  end
                end
              end
            end
            KIND_SET_TIME: begin
              time_nxt   = in_ch.time_value;
              tvalid_nxt = 1'b1;
            end
            KIND_SET_ALARM: begin
              alarm_nxt = in_ch.time_value;
            end
            KIND_ENABLE: begin
              en_nxt    = 1'b1;
              fired_nxt = 1'b0;
            end
            KIND_DISABLE: begin
              en_nxt    = 1'b0;
              fired_nxt = 1'b0;
            end
            KIND_SNOOZE: begin
              fired_nxt = 1'b0;
              if (in_ch.snooze_minutes != '0) begin
                cnt_nxt    = in_ch.snooze_minutes;
                state_nxt  = ST_SNOOZE;
                ovalid_nxt = 1'b0;
              end
            end
            default: begin
              // query and unused code: report state only
            end
          endcase
        end
      end
      ST_SNOOZE: begin
        alarm_nxt = unit_out;
        cnt_nxt   = cnt_r - MIN_W'(1);
        if (cnt_r == {{(MIN_W-1){1'b0}}, 1'b1}) begin
          state_nxt  = ST_IDLE;
          ovalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
